// File: src/cbf_pkg.sv
package cbf_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_HELD  = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_BLOCK = 3'd3,
    MODE_BSTAR = 3'd4,
    MODE_STR   = 3'd5,
    MODE_ESC   = 3'd6
  } cbf_mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BLOCK  = 2'd1,
    ST_STRING = 2'd2
  } cbf_status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } cbf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } cbf_out_t;

  // one classified item: one or two bytes, end mark and status go with the final byte
  typedef struct packed {
    logic        two;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        last;
    cbf_status_t status;
  } cbf_entry_t;

  function automatic logic keep_in_block(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

// File: src/cbf_front.sv
module cbf_front import cbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  cbf_in_t    in_data,
  input  logic       q_full,
  output logic       push,
  output cbf_entry_t push_data
);

  cbf_mode_t mode_r, mode_nxt;
  cbf_mode_t scan_nxt;
  logic [7:0] b;
  logic has_out, two, has_tmp, two_tmp;
  logic [7:0] e0, e1, e0_tmp;
  cbf_status_t st;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign b = (in_data.in_byte == CH_CR) ? CH_SP : in_data.in_byte;

  // per-byte scanner
  always_comb begin
    has_tmp  = 1'b1;
    two      = 1'b0;
    e0_tmp   = b;
    e1       = b;
    scan_nxt = mode_r;
    case (mode_r)
      MODE_HELD: begin
        two = 1'b1;
        if (b == CH_SLASH) begin
          e0_tmp   = CH_SP;
          e1       = CH_SP;
          scan_nxt = MODE_LINE;
        end else if (b == CH_STAR) begin
          e0_tmp   = CH_SP;
          e1       = CH_SP;
          scan_nxt = MODE_BLOCK;
        end else begin
          // the held slash goes out, then the byte as code
          e0_tmp   = CH_SLASH;
          e1       = b;
          scan_nxt = (b == CH_QUOTE) ? MODE_STR : MODE_CODE;
        end
      end
      MODE_LINE: begin
        if (b == CH_LF) begin
          scan_nxt = MODE_CODE;
        end else begin
          e0_tmp = CH_SP;
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) begin
          e0_tmp   = CH_SP;
          scan_nxt = MODE_BSTAR;
        end else begin
          e0_tmp = keep_in_block(b) ? b : CH_SP;
        end
      end
      MODE_BSTAR: begin
        if (b == CH_SLASH) begin
          e0_tmp   = CH_SP;
          scan_nxt = MODE_CODE;
        end else if (b == CH_STAR) begin
          e0_tmp = CH_SP;
        end else begin
          e0_tmp   = keep_in_block(b) ? b : CH_SP;
          scan_nxt = MODE_BLOCK;
        end
      end
      MODE_STR: begin
        if (b == CH_BSL) begin
          scan_nxt = MODE_ESC;
        end else if (b == CH_QUOTE) begin
          scan_nxt = MODE_CODE;
        end
      end
      MODE_ESC: begin
        scan_nxt = MODE_STR;
      end
      default: begin
        if (b == CH_SLASH) begin
          has_tmp  = 1'b0;
          scan_nxt = MODE_HELD;
        end else begin
          scan_nxt = (b == CH_QUOTE) ? MODE_STR : MODE_CODE;
        end
      end
    endcase
  end

  // end of text: flush a held slash, take status, go back to code
  always_comb begin
    has_out  = has_tmp;
    two_tmp  = two;
    e0       = e0_tmp;
    st       = ST_OK;
    mode_nxt = scan_nxt;
    if (in_data.in_last) begin
      if (scan_nxt == MODE_HELD) begin
        has_out = 1'b1;
        e0      = CH_SLASH;
      end
      if (scan_nxt == MODE_BLOCK || scan_nxt == MODE_BSTAR) begin
        st = ST_BLOCK;
      end else if (scan_nxt == MODE_STR || scan_nxt == MODE_ESC) begin
        st = ST_STRING;
      end
      mode_nxt = MODE_CODE;
    end
  end

  assign push             = accept && has_out;
  assign push_data.two    = two_tmp;
  assign push_data.b0     = e0;
  assign push_data.b1     = e1;
  assign push_data.last   = in_data.in_last;
  assign push_data.status = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CODE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  a_last_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.in_last |=> mode_r == MODE_CODE)
    else $error("scan mode not back to code after end of text");

endmodule

// File: src/cbf_queue.sv
module cbf_queue import cbf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cbf_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output cbf_entry_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cbf_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

// File: src/cbf_back.sv
module cbf_back import cbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cbf_entry_t head_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output cbf_out_t   out_data
);

  logic     out_valid_r;
  cbf_out_t out_data_r, out_data_nxt;
  logic     phase_r, phase_nxt;
  logic     load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && head_valid && (!head_data.two || phase_r);

  always_comb begin
    phase_nxt = phase_r;
    if (head_data.two && !phase_r) begin
      out_data_nxt.out_byte = head_data.b0;
      out_data_nxt.out_last = 1'b0;
      out_data_nxt.status   = ST_OK;
      phase_nxt             = 1'b1;
    end else begin
      out_data_nxt.out_byte = head_data.two ? head_data.b1 : head_data.b0;
      out_data_nxt.out_last = head_data.last;
      out_data_nxt.status   = head_data.status;
      phase_nxt             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid && head_data.two)
    else $error("second byte pending without a two-byte entry");

  a_status_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> out_data_r.out_last)
    else $error("nonzero status on a byte that is not the last");

endmodule

// File: src/comment_blanking_filter_unit.sv
// comment blanking filter
// input channel: in_valid / in_stall / in_data, one source byte per word with an
//   end-of-text mark in in_last
// output channel: out_valid / out_stall / out_data, one rewritten byte per word;
//   out_last marks the final byte of the text, status is valid with it
//   (ok, unterminated block comment, unterminated string)
// throughput: one input word per cycle while in_stall is low; a word that yields
//   two bytes (held slash released, comment opener) leaves as two output words, a
//   slash held for lookahead yields nothing until the next byte
// path: an accepted word is written into the queue at the accepting edge, then
//   its first byte moves into the output register once that register is free;
//   the second byte of a pair follows it there after the first is taken
// in_stall rises when the queue between scanner and emitter is full; with
//   out_stall high the output word holds and the queue fills behind it
// reset (rst_n low, synchronous) puts the scanner in code mode and empties the
//   queue and the output register
module comment_blanking_filter_unit import cbf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cbf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cbf_out_t out_data
);

  logic       push, pop, q_full, head_valid;
  cbf_entry_t push_data, head_data;

  cbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  cbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  cbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
